### rtl/pfe_pkg.sv
// shared types and constants of the postfix expression evaluator
// token codes, status codes, queue token and divider request/response structs
// no dependencies
package pfe_pkg;

    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int ST_W        = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    localparam logic [DATA_W-1:0] IRREGULAR_VALUE = 32'h7FFF_FFFF;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_IRREGULAR = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_DIVZERO   = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        K_PUSH = 3'd0,
        K_ADD  = 3'd1,
        K_SUB  = 3'd2,
        K_MUL  = 3'd3,
        K_DIV  = 3'd4,
        K_NOP  = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] value;
        logic              last;
    } token_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/pfe_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pfe_front.sv
// front end: accepts input transactions, classifies the token kind, queues tokens
// depends on pfe_pkg
module pfe_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pfe_pkg::DATA_W-1:0]  s_tdata,   // value
    input  logic [pfe_pkg::OP_W-1:0]    s_tuser,   // op
    input  logic                        s_tlast,   // last
    output logic                        tok_valid,
    output pfe_pkg::token_t             tok,
    input  logic                        tok_pop
);
    import pfe_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    token_t         q_mem_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] q_cnt_reg, q_cnt_next;
    logic           push;
    logic           pop;
    token_t         in_tok;

    always_comb
    begin
        in_tok.value = s_tdata;
        in_tok.last  = s_tlast;
        case (s_tuser)
            OP_PUSH: in_tok.kind = K_PUSH;
            OP_ADD:  in_tok.kind = K_ADD;
            OP_SUB:  in_tok.kind = K_SUB;
            OP_MUL:  in_tok.kind = K_MUL;
            OP_DIV:  in_tok.kind = K_DIV;
            default: in_tok.kind = K_NOP;
        endcase
    end

    assign s_tready  = (q_cnt_reg != QCW'(QUEUE_DEPTH));
    assign tok_valid = (q_cnt_reg != '0);
    assign tok       = q_mem_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = tok_pop && tok_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPW'(1) : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push && !pop)
        begin
            q_cnt_next = q_cnt_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            q_cnt_next = q_cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_tok;
        end
    end

endmodule

### rtl/pfe_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on pfe_pkg
module pfe_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pfe_pkg::div_req_t req,
    output pfe_pkg::div_rsp_t rsp
);
    import pfe_pkg::*;

    localparam int CW = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] mb_reg, mb_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, q_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, mb_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            q_next   = req.dividend[DATA_W-1] ? (~req.dividend + DATA_W'(1)) : req.dividend;
            mb_next  = req.divisor[DATA_W-1] ? (~req.divisor + DATA_W'(1)) : req.divisor;
            neg_next = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                q_next   = {q_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                q_next   = {q_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DATA_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~q_reg + DATA_W'(1)) : q_reg;

endmodule

### rtl/pfe_back.sv
// back end: operand stack sequencer, arithmetic, sticky error and result register
// depends on pfe_pkg, pfe_ram, pfe_div
module pfe_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tok_valid,
    input  pfe_pkg::token_t            tok,
    output logic                       tok_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pfe_pkg::DATA_W-1:0] m_tdata,
    output pfe_pkg::status_t           m_status
);
    import pfe_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int CNW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RDB  = 7'b0000010,
        S_RDA  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_WR   = 7'b0010000,
        S_LAST = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNW-1:0]    count_reg, count_next;
    status_t           sticky_reg, sticky_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    status_t           m_status_reg, m_status_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] r_reg, r_next;
    kind_t             kind_reg, kind_next;
    logic              last_reg, last_next;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;
    logic [CNW-1:0]    cnt_m1;
    logic [CNW-1:0]    cnt_m2;
    logic [DATA_W-1:0] prod;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    state_t            after_tok;
    logic              out_free;

    pfe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pfe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cnt_m1   = count_reg - CNW'(1);
    assign cnt_m2   = count_reg - CNW'(2);
    assign prod     = rdata * b_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign after_tok = last_reg ? S_LAST : S_IDLE;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        sticky_next      = sticky_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_status_next    = m_status_reg;
        b_next           = b_reg;
        r_next           = r_reg;
        kind_next        = kind_reg;
        last_next        = last_reg;
        tok_pop          = 1'b0;
        we               = 1'b0;
        waddr            = count_reg[AW-1:0];
        wdata            = tok.value;
        raddr            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = rdata;
        div_req.divisor  = b_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (tok_valid)
                begin
                    tok_pop   = 1'b1;
                    kind_next = tok.kind;
                    last_next = tok.last;
                    state_next = tok.last ? S_LAST : S_IDLE;
                    if (sticky_reg != ST_OK || tok.kind == K_NOP)
                    begin
                        // token ignored
                    end
                    else if (tok.kind == K_PUSH)
                    begin
                        if (count_reg >= CNW'(STACK_DEPTH))
                        begin
                            sticky_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            we         = 1'b1;
                            count_next = count_reg + CNW'(1);
                        end
                    end
                    else if (count_reg < CNW'(2))
                    begin
                        sticky_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        raddr      = cnt_m1[AW-1:0];
                        state_next = S_RDB;
                    end
                end
            end
            S_RDB:
            begin
                b_next     = rdata;
                raddr      = cnt_m2[AW-1:0];
                state_next = S_RDA;
            end
            S_RDA:
            begin
                state_next = S_WR;
                case (kind_reg)
                    K_ADD:   r_next = rdata + b_reg;
                    K_SUB:   r_next = rdata - b_reg;
                    K_MUL:   r_next = prod;
                    K_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            sticky_next = ST_DIVZERO;
                            state_next  = after_tok;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    default: r_next = r_reg;
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    r_next     = div_rsp.quotient;
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                we         = 1'b1;
                waddr      = cnt_m2[AW-1:0];
                wdata      = r_reg;
                count_next = cnt_m1;
                state_next = after_tok;
            end
            S_LAST:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (sticky_reg != ST_OK)
                    begin
                        m_data_next   = '0;
                        m_status_next = sticky_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        m_data_next   = '0;
                        m_status_next = ST_EMPTY;
                    end
                    else if (count_reg == CNW'(1))
                    begin
                        m_data_next   = rdata;
                        m_status_next = ST_OK;
                    end
                    else
                    begin
                        m_data_next   = IRREGULAR_VALUE;
                        m_status_next = ST_IRREGULAR;
                    end
                    count_next  = '0;
                    sticky_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            sticky_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sticky_reg  <= sticky_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        b_reg        <= b_next;
        r_reg        <= r_next;
        kind_reg     <= kind_next;
        last_reg     <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_status = m_status_reg;

endmodule

### rtl/postfix_expression_evaluator_top.sv
// postfix expression evaluator top level: front queue, stack back end, assertions
// depends on pfe_pkg, pfe_front, pfe_back (pfe_ram, pfe_div)
//
// usage
//   input stream s_*: one token per transaction; s_tuser is the token kind
//   (push, add, subtract, multiply, divide; other codes are ignored), s_tdata
//   the operand for a push, s_tlast marks the final token of an expression
//   output stream m_*: one transaction per expression, sent after the token
//   with s_tlast; m_tdata is the value, m_tuser the status code
//   a two-token queue separates acceptance from execution
//   stack sequencer steps per token: push or ignored token in the idle state;
//   add, subtract, multiply: two stack ram reads with registered data,
//   compute, write back; divide also waits on the one-bit-per-cycle divider;
//   the final token adds a last state, then waits for a free output register;
//   an accepted token is registered in the queue before the sequencer sees it
//   reset clears the queue, stack count, sticky error and output valid;
//   stack contents are not cleared and need no clearing pass
//   a stalled receiver holds the result; tokens keep flowing until the
//   queue fills, then s_tready drops
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [pfe_pkg::DATA_W-1:0] s_tdata,   // value
    input  logic [pfe_pkg::OP_W-1:0]   s_tuser,   // op
    input  logic                       s_tlast,   // last
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pfe_pkg::DATA_W-1:0] m_tdata,   // result
    output logic [pfe_pkg::ST_W-1:0]   m_tuser    // status
);
    import pfe_pkg::*;

    logic    tok_valid;
    token_t  tok;
    logic    tok_pop;
    status_t m_status;

    pfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop)
    );

    pfe_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_status  (m_status)
    );

    assign m_tuser = m_status;

`ifndef ASSERT_OFF
    a_pop_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
        tok_pop |-> tok_valid)
        else $error("token popped from empty queue");

    a_irregular_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_status == ST_IRREGULAR) |-> (m_tdata == IRREGULAR_VALUE))
        else $error("irregular status without saturated value");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_status == ST_UNDERFLOW || m_status == ST_OVERFLOW ||
                      m_status == ST_DIVZERO || m_status == ST_EMPTY))
        |-> (m_tdata == '0))
        else $error("error status with nonzero result");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_pop && !s_tready) |=> !s_tready)
        else $error("queue reported space without a pop");
`endif

endmodule

### test/postfix_expression_evaluator_top_tb.sv
`timescale 1ns / 100ps
// testbench for postfix_expression_evaluator_top: a directed token table, then random expressions
// results are checked against the table where known, else a behavioral stack calculator kept here
// depends on pfe_pkg and the rtl under rtl/
module postfix_expression_evaluator_top_tb;
    import pfe_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_TOKENS  = 800;
    localparam int QUIET_AFTER    = 680;
    localparam int HOLD_AFTER     = 150;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    // token codes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic              last;
    } token_rec_t;

    typedef struct {
        logic [DATA_W-1:0] result;
        status_t           status;
    } outcome_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic              last;
        logic              known;
        logic [DATA_W-1:0] result;
        status_t           status;
    } table_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // value
    logic [OP_W-1:0]   s_tuser;   // op
    logic              s_tlast;   // last
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // result
    logic [ST_W-1:0]   m_tuser;   // status

    logic [DATA_W-1:0] calc_stack [DEPTH];
    int                calc_depth = 0;
    status_t           calc_error = ST_OK;
    outcome_t          expected_q [$];
    token_rec_t        expr_tokens [$];

    int  tokens_counted = 0;
    int  exprs_checked  = 0;
    int  mismatches     = 0;
    int  status_hits [6];
    bit  quiet          = 1'b0;

    table_row_t directed_rows [$] = '{
        '{OP_SPARE_A, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{OP_PUSH,    32'h7FFF_FFFF, 1'b0, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'h0000_0001, 1'b0, 1'b0, '0, ST_OK},
        '{OP_ADD,     32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, ST_OK},
        '{OP_PUSH,    32'h8000_0000, 1'b0, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'hFFFF_FFFF, 1'b0, 1'b0, '0, ST_OK},
        '{OP_DIV,     32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, ST_OK},
        '{OP_PUSH,    32'h0000_0005, 1'b0, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'h0000_0000, 1'b0, 1'b0, '0, ST_OK},
        '{OP_DIV,     32'h0000_0000, 1'b0, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000, ST_DIVZERO},
        '{OP_SUB,     32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
        '{OP_PUSH,    32'h0000_0003, 1'b0, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'h0000_0004, 1'b1, 1'b1, IRREGULAR_VALUE, ST_IRREGULAR},
        '{OP_PUSH,    32'hFFFF_FFF9, 1'b0, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'h0000_0002, 1'b0, 1'b0, '0, ST_OK},
        '{OP_DIV,     32'h0000_0000, 1'b1, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'h8000_0000, 1'b0, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'h0000_0001, 1'b0, 1'b0, '0, ST_OK},
        '{OP_SUB,     32'h0000_0000, 1'b1, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'h0000_0006, 1'b0, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'hFFFF_FFFD, 1'b0, 1'b0, '0, ST_OK},
        '{OP_SPARE_C, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, ST_OK},
        '{OP_MUL,     32'h0000_0000, 1'b1, 1'b0, '0, ST_OK},
        '{OP_PUSH,    32'h0000_0009, 1'b0, 1'b0, '0, ST_OK},
        '{OP_SPARE_B, 32'h1234_5678, 1'b1, 1'b0, '0, ST_OK}
    };

    postfix_expression_evaluator_top #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] divide_toward_zero(logic [DATA_W-1:0] num,
                                                            logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] quo;
        num_mag = num[DATA_W-1] ? -num : num;
        den_mag = den[DATA_W-1] ? -den : den;
        quo = num_mag / den_mag;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
    endfunction

    // advance the calculator by one token; on the last token queue the expected outcome
    function automatic void evaluate_token(token_rec_t tok, logic known, outcome_t known_out);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        logic              ok;
        outcome_t          out;
        if (calc_error == ST_OK)
        begin
            if (tok.op == OP_PUSH)
            begin
                if (calc_depth >= DEPTH)
                    calc_error = ST_OVERFLOW;
                else
                begin
                    calc_stack[calc_depth] = tok.value;
                    calc_depth++;
                end
            end
            else if (tok.op <= OP_DIV)
            begin
                if (calc_depth < 2)
                    calc_error = ST_UNDERFLOW;
                else
                begin
                    rhs = calc_stack[calc_depth-1];
                    lhs = calc_stack[calc_depth-2];
                    ok = 1'b1;
                    res = '0;
                    case (tok.op)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;
                        default:
                        begin
                            if (rhs == '0)
                            begin
                                calc_error = ST_DIVZERO;
                                ok = 1'b0;
                            end
                            else
                                res = divide_toward_zero(lhs, rhs);
                        end
                    endcase
                    if (ok)
                    begin
                        calc_depth--;
                        calc_stack[calc_depth-1] = res;
                    end
                end
            end
        end
        if (tok.last)
        begin
            out.result = '0;
            out.status = calc_error;
            if (calc_error == ST_OK)
            begin
                if (calc_depth == 0)
                    out.status = ST_EMPTY;
                else if (calc_depth == 1)
                    out.result = calc_stack[0];
                else
                begin
                    out.result = IRREGULAR_VALUE;
                    out.status = ST_IRREGULAR;
                end
            end
            calc_depth = 0;
            calc_error = ST_OK;
            expected_q.insert(expected_q.size(), known ? known_out : out);
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'hFFFF_FFFF;
            4, 5: return DATA_W'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return OP_ADD;
            1: return OP_SUB;
            2: return OP_MUL;
            default: return OP_DIV;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_spare();
        return OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    endfunction

    function automatic void add_token(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
        token_rec_t tok;
        tok.op = op;
        tok.value = value;
        tok.last = 1'b0;
        expr_tokens.insert(expr_tokens.size(), tok);
    endfunction

    // valid postfix over n operands, leaving exactly one value
    function automatic void add_wellformed(int n, bit pushes_first);
        int pending;
        int depth;
        pending = n;
        depth = 0;
        while (pending > 0 || depth > 1)
        begin
            if ($urandom_range(0, 19) == 0)
                add_token(pick_spare(), $urandom);
            if (depth >= 2 && (pending == 0 || (!pushes_first && $urandom_range(0, 1) == 0)))
            begin
                add_token(pick_operator(), $urandom);
                depth--;
            end
            else
            begin
                add_token(OP_PUSH, pick_value());
                pending--;
                depth++;
            end
        end
    endfunction

    function automatic void build_expression();
        int mode;
        expr_tokens.delete();
        mode = $urandom_range(0, 99);
        if (mode < 55)
            add_wellformed($urandom_range(1, 6), 1'b0);
        else if (mode < 63)
            add_wellformed($urandom_range(7, DEPTH), $urandom_range(0, 1));
        else if (mode < 71)
        begin
            // leftover values
            add_wellformed($urandom_range(1, 6), 1'b0);
            repeat ($urandom_range(1, 3)) add_token(OP_PUSH, pick_value());
        end
        else if (mode < 78)
        begin
            // push past a full stack
            repeat ($urandom_range(DEPTH + 1, DEPTH + 3)) add_token(OP_PUSH, pick_value());
            if ($urandom_range(0, 1) == 1)
                add_token(pick_operator(), $urandom);
        end
        else if (mode < 83)
            repeat ($urandom_range(1, 3)) add_token(pick_spare(), $urandom);
        else if (mode < 88)
        begin
            // operator short of operands
            add_wellformed($urandom_range(1, 3), 1'b0);
            repeat ($urandom_range(1, 2)) add_token(pick_operator(), $urandom);
        end
        else
            repeat ($urandom_range(1, 8)) add_token(OP_W'($urandom_range(0, 7)), $urandom);
        expr_tokens[$].last = 1'b1;
    endfunction

    task automatic send_token(token_rec_t tok, logic known, outcome_t known_out);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= tok.op;
        s_tdata  <= tok.value;
        s_tlast  <= tok.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        evaluate_token(tok, known, known_out);
        if (tok.op <= OP_DIV || tok.last)
            tokens_counted++;
    endtask

    initial
    begin : stimulus
        token_rec_t tok;
        outcome_t   known_out;
        int         random_start;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_PUSH;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            tok.op = directed_rows[i].op;
            tok.value = directed_rows[i].value;
            tok.last = directed_rows[i].last;
            known_out.result = directed_rows[i].result;
            known_out.status = directed_rows[i].status;
            send_token(tok, directed_rows[i].known, known_out);
        end
        random_start = tokens_counted;
        known_out.result = '0;
        known_out.status = ST_OK;
        while (tokens_counted - random_start < RANDOM_TOKENS)
        begin
            build_expression();
            foreach (expr_tokens[i])
                send_token(expr_tokens[i], 1'b0, known_out);
            if (tokens_counted - random_start >= QUIET_AFTER)
                quiet = 1'b1;
        end
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d tokens, %0d expressions checked, %0d mismatches",
                 tokens_counted, exprs_checked, mismatches);
        $display("summary: ok %0d irregular %0d underflow %0d overflow %0d divzero %0d empty %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side: random stall bursts, one long hold to back up the input
    initial
    begin : result_sink
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && tokens_counted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected transaction result %h status %0d",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                exprs_checked++;
                status_hits[int'(want.status)]++;
                if (m_tdata !== want.result)
                begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $time, want.result, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end
    end

endmodule
